/* rtl/core/gmsp_pkg.sv */
// Shared types, register map and reset constants of the global scan MPPT tracker.
`timescale 1ns / 1ps

package gmsp_pkg;

	localparam int ADC_BITS_DEF    = 10;
	localparam int OSC_LIMIT_DEF   = 4;
	localparam int START_SPEED_DEF = 4;

	localparam int DUTY_W   = 8;
	localparam int VCFG_W   = 10;
	localparam int THR_W    = 20;
	localparam int WIN_W    = 30;
	localparam int SPEED_W  = 3;
	localparam int OSC_W    = 3;
	localparam int ZONE_W   = 2;
	localparam int SHIFT_W  = 3;
	localparam int APB_AW   = 5;
	localparam int APB_DW   = 32;

	localparam logic [ZONE_W-1:0]  ZONE_DONE       = 2'd3;
	localparam logic [SHIFT_W-1:0] SCAN_SHIFT_BASE = 3'd3;

	localparam logic [DUTY_W-1:0] MIN_DUTY_RST   = 8'd32;
	localparam logic [DUTY_W-1:0] MAX_DUTY_RST   = 8'd230;
	localparam logic [DUTY_W-1:0] DUTY_RST       = 8'd230;
	localparam logic [THR_W-1:0]  RESCAN_THR_RST = 20'd1000;
	localparam logic [WIN_W-1:0]  ZONE0_WIN_RST  = 30'd377866590;
	localparam logic [WIN_W-1:0]  ZONE1_WIN_RST  = 30'd650773080;
	localparam logic [WIN_W-1:0]  ZONE2_WIN_RST  = 30'd913188675;
	localparam logic [VCFG_W-1:0] FINE_V_RST     = 10'd680;
	localparam logic [VCFG_W-1:0] MEDIUM_V_RST   = 10'd470;

	typedef enum logic [1:0] {
		MODE_PO     = 2'd0,
		MODE_SCAN   = 2'd1,
		MODE_STEADY = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		REG_MIN_DUTY   = 3'd0,
		REG_MAX_DUTY   = 3'd1,
		REG_RESCAN_THR = 3'd2,
		REG_ZONE0_WIN  = 3'd3,
		REG_ZONE1_WIN  = 3'd4,
		REG_ZONE2_WIN  = 3'd5,
		REG_FINE_V     = 3'd6,
		REG_MEDIUM_V   = 3'd7
	} reg_idx_t;

endpackage

/* rtl/core/global_mppt_sweep_and_po.sv */
// Global scan plus adaptive perturb-and-observe MPPT tracker top level.
// The input register frees whenever the result register advances, which out_ready can stall.
// Throughput: one item per cycle while the result register is not stalled.
// The power multiply and the mode update are combinational between the two registers.
// Reset (arst_n low, asynchronous): steady mode, duty 230, all tracking state cleared,
// configuration registers at their defaults, both pipeline registers empty.
`timescale 1ns / 1ps

module global_mppt_sweep_and_po #(
	parameter int ADC_BITS          = gmsp_pkg::ADC_BITS_DEF,
	parameter int OSCILLATION_LIMIT = gmsp_pkg::OSC_LIMIT_DEF,
	parameter int START_SPEED       = gmsp_pkg::START_SPEED_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gmsp_pkg::APB_AW-1:0]  paddr,
	input  logic [gmsp_pkg::APB_DW-1:0]  pwdata,
	output logic [gmsp_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ADC_BITS-1:0]          pv_voltage,
	input  logic [ADC_BITS-1:0]          pv_current,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [gmsp_pkg::DUTY_W-1:0]  duty,
	output logic [1:0]                   tracker_mode
);
	import gmsp_pkg::*;

	localparam int PW = 2 * ADC_BITS;
	localparam int VW = (ADC_BITS > VCFG_W) ? ADC_BITS : VCFG_W;
	localparam int TW = (PW > THR_W) ? PW : THR_W;
	localparam int DW = VW + 2;

	// configuration
	logic [DUTY_W-1:0] min_duty_q, max_duty_q;
	logic [THR_W-1:0]  rescan_thr_q;
	logic [WIN_W-1:0]  zone_win_q [3];
	logic [VCFG_W-1:0] fine_v_q, medium_v_q;
	reg_idx_t          cfg_idx;
	logic              cfg_wr;

	// pipeline
	logic                valid_s1;
	logic [ADC_BITS-1:0] pv_voltage_s1, pv_current_s1;
	logic                out_valid_q;
	logic                adv;

	// tracker state
	logic [DUTY_W-1:0] duty_q, duty_d;
	mode_t             mode_q, mode_d;
	logic [ZONE_W-1:0] zone_q, zone_d;
	logic [DUTY_W-1:0] zone_duty_q [3];
	logic [DUTY_W-1:0] zone_duty_d [3];
	logic [PW-1:0]     scan_best_p_q, scan_best_p_d;
	logic [DUTY_W-1:0] scan_best_duty_q, scan_best_duty_d;
	logic [ADC_BITS-1:0] prev_v_q, prev_v_d;
	logic [PW-1:0]     prev_p_q, prev_p_d;
	logic signed [PW:0] prev_dp_q, prev_dp_d;
	logic [PW-1:0]     track_best_p_q, track_best_p_d;
	logic [DUTY_W-1:0] track_best_duty_q, track_best_duty_d;
	logic [SPEED_W-1:0] speed_q, speed_d;
	logic [OSC_W-1:0]  osc_q, osc_d;

	// datapath
	logic [PW-1:0]       power;
	logic [VW-1:0]       v_ext, lo_ext, hi_ext, tg_ext, v_off;
	logic [WIN_W-1:0]    win;
	logic [SHIFT_W-1:0]  sh;
	logic signed [PW:0]  dp;
	logic                dp_ge0, dp_le0, dv_ge0, dv_le0, pd_ge0, pd_le0;
	logic [SPEED_W-1:0]  step;
	logic [SPEED_W-1:0]  speed_n;
	logic [OSC_W-1:0]    osc_n;
	logic [DUTY_W-1:0]   zone_next_duty;
	logic [PW-1:0]       p_diff;
	logic signed [DW-1:0] duty_ext, d_full, min_ext, max_ext;

	assign pready   = 1'b1;
	assign cfg_idx  = reg_idx_t'(paddr[4:2]);
	assign cfg_wr   = psel && penable && pwrite;

	always_comb begin
		case (cfg_idx)
			REG_MIN_DUTY:   prdata = APB_DW'(min_duty_q);
			REG_MAX_DUTY:   prdata = APB_DW'(max_duty_q);
			REG_RESCAN_THR: prdata = APB_DW'(rescan_thr_q);
			REG_ZONE0_WIN:  prdata = APB_DW'(zone_win_q[0]);
			REG_ZONE1_WIN:  prdata = APB_DW'(zone_win_q[1]);
			REG_ZONE2_WIN:  prdata = APB_DW'(zone_win_q[2]);
			REG_FINE_V:     prdata = APB_DW'(fine_v_q);
			REG_MEDIUM_V:   prdata = APB_DW'(medium_v_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_duty_q    <= MIN_DUTY_RST;
			max_duty_q    <= MAX_DUTY_RST;
			rescan_thr_q  <= RESCAN_THR_RST;
			zone_win_q[0] <= ZONE0_WIN_RST;
			zone_win_q[1] <= ZONE1_WIN_RST;
			zone_win_q[2] <= ZONE2_WIN_RST;
			fine_v_q      <= FINE_V_RST;
			medium_v_q    <= MEDIUM_V_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_MIN_DUTY:   min_duty_q    <= pwdata[DUTY_W-1:0];
				REG_MAX_DUTY:   max_duty_q    <= pwdata[DUTY_W-1:0];
				REG_RESCAN_THR: rescan_thr_q  <= pwdata[THR_W-1:0];
				REG_ZONE0_WIN:  zone_win_q[0] <= pwdata[WIN_W-1:0];
				REG_ZONE1_WIN:  zone_win_q[1] <= pwdata[WIN_W-1:0];
				REG_ZONE2_WIN:  zone_win_q[2] <= pwdata[WIN_W-1:0];
				REG_FINE_V:     fine_v_q      <= pwdata[VCFG_W-1:0];
				REG_MEDIUM_V:   medium_v_q    <= pwdata[VCFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pv_voltage_s1 <= pv_voltage;
			pv_current_s1 <= pv_current;
		end
	end

	always_comb begin
		power    = PW'(pv_voltage_s1) * PW'(pv_current_s1);
		v_ext    = VW'(pv_voltage_s1);
		duty_ext = $signed({{(DW-DUTY_W){1'b0}}, duty_q});
		min_ext  = $signed({{(DW-DUTY_W){1'b0}}, min_duty_q});
		max_ext  = $signed({{(DW-DUTY_W){1'b0}}, max_duty_q});

		case (zone_q)
			2'd0:    win = zone_win_q[0];
			2'd1:    win = zone_win_q[1];
			2'd2:    win = zone_win_q[2];
			default: win = '0;
		endcase
		lo_ext = VW'(win[9:0]);
		hi_ext = VW'(win[19:10]);
		tg_ext = VW'(win[29:20]);
		sh     = SCAN_SHIFT_BASE + SHIFT_W'(zone_q);
		v_off  = (v_ext < tg_ext) ? (tg_ext - v_ext) : (v_ext - tg_ext);
		v_off  = v_off >> sh;

		dp     = $signed({1'b0, power}) - $signed({1'b0, prev_p_q});
		dp_ge0 = !dp[PW];
		dp_le0 = dp[PW] || (dp == '0);
		dv_ge0 = pv_voltage_s1 >= prev_v_q;
		dv_le0 = pv_voltage_s1 <= prev_v_q;
		pd_ge0 = !prev_dp_q[PW];
		pd_le0 = prev_dp_q[PW] || (prev_dp_q == '0);

		if (v_ext >= VW'(fine_v_q)) begin
			step = speed_q;
		end else if (v_ext >= VW'(medium_v_q)) begin
			step = speed_q >> 1;
		end else begin
			step = '0;
		end

		p_diff = (power > track_best_p_q) ? (power - track_best_p_q)
		                                  : (track_best_p_q - power);

		mode_d            = mode_q;
		zone_d            = zone_q;
		zone_duty_d       = zone_duty_q;
		scan_best_p_d     = scan_best_p_q;
		scan_best_duty_d  = scan_best_duty_q;
		prev_v_d          = prev_v_q;
		prev_p_d          = prev_p_q;
		prev_dp_d         = prev_dp_q;
		track_best_p_d    = track_best_p_q;
		track_best_duty_d = track_best_duty_q;
		speed_d           = speed_q;
		osc_d             = osc_q;
		speed_n           = speed_q;
		osc_n             = osc_q;
		zone_next_duty    = '0;
		d_full            = duty_ext;

		case (mode_q)
			MODE_SCAN: begin
				if (zone_q < ZONE_DONE) begin
					if (v_ext < lo_ext || v_ext > hi_ext) begin
						if (v_ext < tg_ext) begin
							d_full = duty_ext - $signed({2'b00, v_off});
						end else begin
							d_full = duty_ext + $signed({2'b00, v_off});
						end
					end else begin
						for (int i = 0; i < 3; i++) begin
							if (ZONE_W'(i) == zone_q) begin
								zone_duty_d[i] = duty_q;
							end
						end
						if (power > scan_best_p_q) begin
							scan_best_p_d    = power;
							scan_best_duty_d = duty_q;
						end
						zone_d = zone_q + 2'd1;
						case (zone_d)
							2'd1:    zone_next_duty = zone_duty_q[1];
							2'd2:    zone_next_duty = zone_duty_q[2];
							default: zone_next_duty = scan_best_duty_d;
						endcase
						d_full = $signed({{(DW-DUTY_W){1'b0}}, zone_next_duty});
						if (zone_d == ZONE_DONE) begin
							prev_v_d          = '0;
							prev_p_d          = '0;
							prev_dp_d         = '0;
							speed_d           = SPEED_W'(START_SPEED);
							track_best_p_d    = '0;
							track_best_duty_d = '0;
							mode_d            = MODE_PO;
						end
					end
				end
			end
			MODE_PO: begin
				if (power > track_best_p_q) begin
					track_best_duty_d = duty_q;
					track_best_p_d    = power;
				end
				if (prev_p_q != '0) begin
					if ((dp_ge0 && dv_ge0) || (dp_le0 && dv_le0)) begin
						d_full = duty_ext - $signed({{(DW-SPEED_W){1'b0}}, step});
					end else begin
						d_full = duty_ext + $signed({{(DW-SPEED_W){1'b0}}, step});
					end
					if (osc_q < OSC_W'(OSCILLATION_LIMIT)) begin
						if ((pd_ge0 && dp_le0) || (pd_le0 && dp_ge0)) begin
							osc_n = osc_q + 3'd1;
						end else begin
							osc_n = '0;
						end
					end
					if (osc_n == OSC_W'(OSCILLATION_LIMIT) && speed_q != '0) begin
						speed_n = speed_q >> 1;
						osc_n   = '0;
					end
					if (speed_n == '0) begin
						mode_d = MODE_STEADY;
						osc_n  = '0;
						d_full = $signed({{(DW-DUTY_W){1'b0}}, track_best_duty_d});
					end
					osc_d   = osc_n;
					speed_d = speed_n;
				end
				prev_dp_d = dp;
				prev_v_d  = pv_voltage_s1;
				prev_p_d  = power;
			end
			MODE_STEADY: begin
				if (TW'(p_diff) > TW'(rescan_thr_q)) begin
					mode_d           = MODE_SCAN;
					track_best_p_d   = '0;
					scan_best_p_d    = '0;
					scan_best_duty_d = '0;
					zone_d           = '0;
				end
			end
			default: begin
			end
		endcase

		if (d_full > max_ext) begin
			duty_d = max_duty_q;
		end else if (d_full < min_ext) begin
			duty_d = min_duty_q;
		end else begin
			duty_d = d_full[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q       <= 1'b0;
			duty_q            <= DUTY_RST;
			mode_q            <= MODE_STEADY;
			zone_q            <= '0;
			zone_duty_q[0]    <= '0;
			zone_duty_q[1]    <= '0;
			zone_duty_q[2]    <= '0;
			scan_best_p_q     <= '0;
			scan_best_duty_q  <= '0;
			prev_v_q          <= '0;
			prev_p_q          <= '0;
			prev_dp_q         <= '0;
			track_best_p_q    <= '0;
			track_best_duty_q <= '0;
			speed_q           <= '0;
			osc_q             <= '0;
		end else begin
			if (adv) begin
				out_valid_q       <= 1'b1;
				duty_q            <= duty_d;
				mode_q            <= mode_d;
				zone_q            <= zone_d;
				zone_duty_q       <= zone_duty_d;
				scan_best_p_q     <= scan_best_p_d;
				scan_best_duty_q  <= scan_best_duty_d;
				prev_v_q          <= prev_v_d;
				prev_p_q          <= prev_p_d;
				prev_dp_q         <= prev_dp_d;
				track_best_p_q    <= track_best_p_d;
				track_best_duty_q <= track_best_duty_d;
				speed_q           <= speed_d;
				osc_q             <= osc_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign duty         = duty_q;
	assign tracker_mode = mode_q;

`ifndef SYNTHESIS
	a_duty_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (min_duty_q <= max_duty_q) |=>
		(duty_q >= $past(min_duty_q)) && (duty_q <= $past(max_duty_q)))
		else $error("duty left the min/max window");

	a_po_speed_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_PO) |-> (speed_q != '0))
		else $error("P&O mode with zero speed");

	a_po_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_PO) |-> (zone_q == ZONE_DONE))
		else $error("P&O mode before the scan finished");

	a_osc_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		osc_q < OSC_W'(OSCILLATION_LIMIT))
		else $error("oscillation count reached its limit");
`endif

endmodule
